// ----- design/top_k_sorted_insert_defines.svh -----
// ----------------------------------------------------------------------------
// top_k_sorted_insert_defines
// Assertion macros shared by the top-k insert checker.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SORTED_INSERT_DEFINES_SVH
`define TOP_K_SORTED_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define TKSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define TKSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tksi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_pkg
// Types and constants of the top-k sorted insert block.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int RANKS_DEF  = 16;
    localparam int TABLES_DEF = 3;

    localparam logic signed [31:0] INIT_SCORE = 32'sd666;
    localparam logic [6:0]         INIT_RATIO = 7'd100;

    typedef enum logic {
        REQ_SUBMIT = 1'b0,
        REQ_READ   = 1'b1
    } req_e;

    typedef struct packed {
        logic signed [31:0] score;
        logic [6:0]         ratio;
        logic [15:0]        waves;
    } rec_t;

    localparam rec_t RESET_REC = '{score: INIT_SCORE, ratio: INIT_RATIO, waves: 16'd0};

    typedef struct packed {
        logic               req_type;
        logic [1:0]         table_sel;
        logic signed [31:0] new_score;
        logic [6:0]         new_hit_ratio;
        logic [15:0]        new_waves;
        logic [3:0]         read_rank;
    } in_item_t;

    typedef struct packed {
        logic               admitted;
        logic [3:0]         taken_rank;
        logic signed [31:0] out_score;
        logic [6:0]         out_hit_ratio;
        logic [15:0]        out_waves;
    } out_item_t;

    // Broadcast from the top level to every rank cell.
    typedef struct packed {
        logic insert_en;
        rec_t rec;
    } cell_cmd_t;

endpackage

// ----- design/tksi_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_cell
// One rank position: holds that rank's record for every table, compares it
// with the submitted score and takes the new record or its upper neighbor's.
// ----------------------------------------------------------------------------
module tksi_cell #(
    parameter int TABLES  = tksi_pkg::TABLES_DEF,
    parameter bit IS_LAST = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tksi_pkg::cell_cmd_t   cmd,
    input  logic [TABLES-1:0]     tab_hit,
    input  tksi_pkg::rec_t        prev_rec,
    input  logic                  prev_lt,
    output tksi_pkg::rec_t        sel_rec,
    output logic                  lt,
    output logic                  ins
);
    import tksi_pkg::*;

    rec_t rec_reg  [TABLES];
    rec_t rec_next [TABLES];

    always_comb begin
        sel_rec = '0;
        for (int t = 0; t < TABLES; t++) begin
            if (tab_hit[t]) begin
                sel_rec = rec_reg[t];
            end
        end
    end

    // last rank also admits an equal score
    always_comb begin
        if (IS_LAST) begin
            lt = ($signed(cmd.rec.score) >= $signed(sel_rec.score));
        end else begin
            lt = ($signed(sel_rec.score) < $signed(cmd.rec.score));
        end
        ins = lt && !prev_lt;
    end

    always_comb begin
        for (int t = 0; t < TABLES; t++) begin
            rec_next[t] = rec_reg[t];
            if (cmd.insert_en && tab_hit[t] && lt) begin
                rec_next[t] = ins ? cmd.rec : prev_rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int t = 0; t < TABLES; t++) begin
            if (!aresetn) begin
                rec_reg[t] <= RESET_REC;
            end else begin
                rec_reg[t] <= rec_next[t];
            end
        end
    end

endmodule

// ----- design/top_k_sorted_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Several descending-sorted top-k tables with stable insert and rank read.
// ----------------------------------------------------------------------------
// The accept edge registers each item; once the output register is free or
// being taken, a row of RANKS cells compares every stored score of the
// addressed table with the new one in parallel, each cell loading the new
// record or its upper neighbor's, while the result goes to the output
// register. The input side is then ready again, so one item can wait in
// the input register while a result waits to be taken. Reset loads every
// entry with score 666, ratio 100, waves 0 at once; no clearing pass.
module top_k_sorted_insert #(
    parameter int RANKS  = tksi_pkg::RANKS_DEF,
    parameter int TABLES = tksi_pkg::TABLES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tksi_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tksi_pkg::out_item_t m_item
);
    import tksi_pkg::*;

    logic      busy_reg, busy_next;
    in_item_t  in_reg, in_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t out_reg, out_next;

    logic              exec;
    logic              tab_ok;
    logic [TABLES-1:0] tab_hit;
    cell_cmd_t         cmd;
    rec_t              cell_rec [RANKS];
    logic              cell_lt  [RANKS];
    logic              cell_ins [RANKS];
    rec_t              rd_rec;
    logic [3:0]        ins_rank;

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign exec   = busy_reg && (!m_valid_reg || m_ready);
    assign tab_ok = (32'(in_reg.table_sel) < TABLES);

    always_comb begin
        for (int t = 0; t < TABLES; t++) begin
            tab_hit[t] = busy_reg && (32'(in_reg.table_sel) == t);
        end
        cmd.insert_en = exec && tab_ok && (in_reg.req_type == REQ_SUBMIT);
        cmd.rec.score = in_reg.new_score;
        cmd.rec.ratio = in_reg.new_hit_ratio;
        cmd.rec.waves = in_reg.new_waves;
    end

    for (genvar r = 0; r < RANKS; r++) begin : g_cell
        if (r == 0) begin : g_first
            tksi_cell #(.TABLES(TABLES), .IS_LAST(1'b0)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .tab_hit  (tab_hit),
                .prev_rec ('0),
                .prev_lt  (1'b0),
                .sel_rec  (cell_rec[r]),
                .lt       (cell_lt[r]),
                .ins      (cell_ins[r])
            );
        end else begin : g_next
            tksi_cell #(.TABLES(TABLES), .IS_LAST(r == RANKS - 1)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .tab_hit  (tab_hit),
                .prev_rec (cell_rec[r-1]),
                .prev_lt  (cell_lt[r-1]),
                .sel_rec  (cell_rec[r]),
                .lt       (cell_lt[r]),
                .ins      (cell_ins[r])
            );
        end
    end

    always_comb begin
        rd_rec   = '0;
        ins_rank = '0;
        for (int r = 0; r < RANKS; r++) begin
            if (32'(in_reg.read_rank) == r) begin
                rd_rec = cell_rec[r];
            end
            if (cell_ins[r]) begin
                ins_rank = ins_rank | 4'(r);
            end
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        in_next      = in_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exec) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            out_next     = '0;
            if (in_reg.req_type == REQ_READ) begin
                out_next.out_score     = rd_rec.score;
                out_next.out_hit_ratio = rd_rec.ratio;
                out_next.out_waves     = rd_rec.waves;
            end else if (tab_ok && cell_lt[RANKS-1]) begin
                out_next.admitted   = 1'b1;
                out_next.taken_rank = ins_rank;
            end
        end
        if (s_valid && s_ready) begin
            busy_next = 1'b1;
            in_next   = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg  <= in_next;
        out_reg <= out_next;
    end

endmodule

// ----- design/tksi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_checker
// Port-level checks of the top-k insert block, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_sorted_insert_defines.svh"

module tksi_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tksi_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input tksi_pkg::out_item_t m_item
);
    import tksi_pkg::*;

    `TKSI_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_item), "input item changed while waiting")
    `TKSI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result item changed while stalled")
    `TKSI_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input accepted on consecutive cycles")
    `TKSI_ASSERT_NOW(a_submit_no_record, m_valid && m_item.admitted, (m_item.out_score == 0) && (m_item.out_hit_ratio == 0) && (m_item.out_waves == 0), "admitted item carries record data")
    `TKSI_ASSERT_NOW(a_refused_rank, m_valid && !m_item.admitted, m_item.taken_rank == 0, "rank reported without admission")

endmodule

bind top_k_sorted_insert tksi_checker u_tksi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ----- tb/top_k_sorted_insert_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_test
// Self-checking testbench for the top-k sorted insert block.
// ----------------------------------------------------------------------------
// A behavioral copy of the ranking tables predicts every result. The sequence
// is a check of the reset contents, a short set of boundary cases, and then
// random submit and read traffic. The random traffic runs in four phases:
// no idling, an idle sender, a stalling receiver, and light idling on both
// sides. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_test;
    import tksi_pkg::*;

    localparam int RANKS       = RANKS_DEF;
    localparam int TABLES      = TABLES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    top_k_sorted_insert dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    rec_t      standings [TABLES][RANKS];
    out_item_t pending_results [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("top_k_sorted_insert_test: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_standings();
        for (int t = 0; t < TABLES; t++)
            for (int r = 0; r < RANKS; r++)
                standings[t][r] = RESET_REC;
    endfunction

    // Applies one accepted item to the predicted tables, returns its result.
    function automatic out_item_t rank_outcome(in_item_t it);
        out_item_t          res;
        logic signed [31:0] sc;
        logic signed [31:0] held;
        int                 t;
        int                 pos;
        res = '0;
        t   = int'(it.table_sel);
        sc  = it.new_score;
        if (t >= TABLES)
            return res;
        if (it.req_type == REQ_READ) begin
            if (it.read_rank < RANKS) begin
                res.out_score     = standings[t][it.read_rank].score;
                res.out_hit_ratio = standings[t][it.read_rank].ratio;
                res.out_waves     = standings[t][it.read_rank].waves;
            end
            return res;
        end
        held = standings[t][RANKS-1].score;
        if (sc < held)
            return res;
        pos = RANKS - 1;
        for (int r = 0; r < RANKS - 1; r++) begin
            held = standings[t][r].score;
            if (held < sc) begin
                pos = r;
                break;
            end
        end
        for (int r = RANKS - 1; r > pos; r--)
            standings[t][r] = standings[t][r-1];
        standings[t][pos].score = sc;
        standings[t][pos].ratio = it.new_hit_ratio;
        standings[t][pos].waves = it.new_waves;
        res.admitted   = 1'b1;
        res.taken_rank = pos[3:0];
        return res;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(rank_outcome(it));
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (m_item.admitted !== want.admitted)
                    report_mismatch($sformatf("admitted %0b, expected %0b",
                        m_item.admitted, want.admitted));
                if (m_item.taken_rank !== want.taken_rank)
                    report_mismatch($sformatf("taken_rank %0d, expected %0d",
                        m_item.taken_rank, want.taken_rank));
                if (m_item.out_score !== want.out_score)
                    report_mismatch($sformatf("out_score %0d, expected %0d",
                        m_item.out_score, want.out_score));
                if (m_item.out_hit_ratio !== want.out_hit_ratio)
                    report_mismatch($sformatf("out_hit_ratio %0d, expected %0d",
                        m_item.out_hit_ratio, want.out_hit_ratio));
                if (m_item.out_waves !== want.out_waves)
                    report_mismatch($sformatf("out_waves %0d, expected %0d",
                        m_item.out_waves, want.out_waves));
            end
        end
    end

    function automatic in_item_t make_item(req_e kind, int t, logic signed [31:0] sc,
                                           int ratio, int waves, int rank);
        in_item_t it;
        it.req_type      = kind;
        it.table_sel     = t[1:0];
        it.new_score     = sc;
        it.new_hit_ratio = ratio[6:0];
        it.new_waves     = waves[15:0];
        it.read_rank     = rank[3:0];
        return it;
    endfunction

    task automatic test_reset_state();
        for (int t = 0; t <= TABLES; t++) begin
            send_item(make_item(REQ_READ, t, 0, 0, 0, 0));
            send_item(make_item(REQ_READ, t, 0, 0, 0, RANKS - 1));
        end
    endtask

    task automatic test_edge_cases();
        send_item(make_item(REQ_SUBMIT, 0, 32'sd665, 55, 1234, 0));
        send_item(make_item(REQ_SUBMIT, 0, 32'sd666, 0, 0, 0));
        send_item(make_item(REQ_READ, 0, 0, 0, 0, RANKS - 1));
        send_item(make_item(REQ_SUBMIT, 0, 32'sh7fffffff, 100, 65535, 15));
        send_item(make_item(REQ_SUBMIT, 0, 32'sh80000000, 100, 65535, 15));
        send_item(make_item(REQ_READ, 0, 0, 0, 0, 0));
        send_item(make_item(REQ_SUBMIT, 3, 32'sh7fffffff, 100, 65535, 15));
        send_item(make_item(REQ_READ, 3, 0, 0, 0, 15));
        send_item(make_item(REQ_SUBMIT, 1, 32'sd667, 99, 43690, 0));
        send_item(make_item(REQ_SUBMIT, 1, 32'sd667, 27, 21845, 0));
        send_item(make_item(REQ_SUBMIT, 1, 32'sd666, 1, 1, 0));
        send_item(make_item(REQ_READ, 1, 0, 0, 0, 0));
        send_item(make_item(REQ_READ, 1, 0, 0, 0, 1));
        send_item(make_item(REQ_READ, 1, 0, 0, 0, RANKS - 1));
        send_item(make_item(REQ_SUBMIT, 2, -32'sd1, 10, 10, 0));
        send_item(make_item(REQ_SUBMIT, 2, 32'sd0, 10, 10, 0));
        send_item(make_item(REQ_READ, 2, 0, 0, 0, 2));
        send_item(make_item(REQ_READ, 0, 0, 0, 0, 1));
    endtask

    function automatic logic signed [31:0] pick_score(int t);
        int pick;
        int b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return $urandom;
        if (pick < 60) begin
            b = standings[(t < TABLES) ? t : 0][$urandom_range(0, RANKS - 1)].score;
            return b + $urandom_range(0, 2) - 1;
        end
        if (pick < 85)
            return $urandom_range(600, 800);
        case ($urandom_range(0, 3))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        int t;
        req_e kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            t    = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, TABLES - 1);
            kind = ($urandom_range(0, 99) < 45) ? REQ_READ : REQ_SUBMIT;
            send_item(make_item(kind, t, pick_score(t), $urandom_range(0, 100),
                                $urandom_range(0, 65535), $urandom_range(0, 15)));
        end
    endtask

    initial begin
        clear_standings();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_edge_cases();
        test_random_traffic(170, 0, 0);
        test_random_traffic(160, 83, 0);
        test_random_traffic(160, 0, 83);
        test_random_traffic(160, 14, 14);
        s_valid        <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected items never arrived",
                pending_results.size()));
        if (mismatch_count == 0) begin
            $display("top_k_sorted_insert_test: PASS");
        end else begin
            $display("top_k_sorted_insert_test: FAIL");
        end
        $finish;
    end

endmodule
